/* hw/rtl/fpp_pkg.sv */
// Shared types, character codes and a helper function for the position text parser.
package fpp_pkg;

  localparam int unsigned NumMaps = 12;
  localparam int unsigned MapIdxW = 4;
  localparam int unsigned BoardSq = 64;
  localparam int unsigned EpW     = 12;

  localparam logic [MapIdxW-1:0] LastMap = MapIdxW'(NumMaps - 1);

  // Character codes
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowW  = 8'h77;
  localparam logic [7:0] CharUpK   = 8'h4B;
  localparam logic [7:0] CharUpQ   = 8'h51;
  localparam logic [7:0] CharLowK  = 8'h6B;
  localparam logic [7:0] CharLowQ  = 8'h71;

  // Square counter reset value and rank step
  localparam logic [7:0] SqStart = 8'd56;
  localparam logic [7:0] SqRank  = 8'd16;

  // Token numbers
  localparam logic [2:0] TokPlace  = 3'd1;
  localparam logic [2:0] TokSide   = 3'd2;
  localparam logic [2:0] TokCastle = 3'd3;
  localparam logic [2:0] TokPass   = 3'd4;
  localparam logic [2:0] TokMax    = 3'd5;

  typedef logic [NumMaps-1:0][BoardSq-1:0] maps_t;

  // One finished run, handed from the parser to the emitter
  typedef struct packed {
    maps_t          maps;
    logic           white;
    logic [3:0]     rights;
    logic [EpW-1:0] ep;
  } run_rec_t;

  typedef struct packed {
    logic           hit;
    logic [MapIdxW-1:0] idx;
  } piece_t;

  // Map a character onto its occupancy map, if it is a piece letter
  function automatic piece_t piece_lookup(logic [7:0] c);
    piece_t p;
    p.hit = 1'b1;
    case (c)
      8'h50:   p.idx = 4'd0;   // P
      8'h4E:   p.idx = 4'd1;   // N
      8'h42:   p.idx = 4'd2;   // B
      8'h52:   p.idx = 4'd3;   // R
      8'h51:   p.idx = 4'd4;   // Q
      8'h4B:   p.idx = 4'd5;   // K
      8'h70:   p.idx = 4'd6;   // p
      8'h6E:   p.idx = 4'd7;   // n
      8'h62:   p.idx = 4'd8;   // b
      8'h72:   p.idx = 4'd9;   // r
      8'h71:   p.idx = 4'd10;  // q
      8'h6B:   p.idx = 4'd11;  // k
      default: begin
        p.hit = 1'b0;
        p.idx = 4'd0;
      end
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/fpp_front.sv */
// Front end: tokenises the character stream and builds the run record.
module fpp_front import fpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       push_o,
  output run_rec_t   rec_o
);

  maps_t       maps_q, maps_d;
  logic [7:0]  sq_q, sq_d;
  logic [2:0]  tok_q, tok_d;
  logic        in_tok_q, in_tok_d;
  logic [1:0]  len_q, len_d;
  logic [7:0]  side_q, side_d;
  logic [3:0]  rights_q, rights_d;
  logic [15:0] pass_q, pass_d;

  logic        is_space;
  piece_t      pc;
  logic [EpW-1:0] rank_w, file_w;

  assign is_space = (char_code_i == CharSpace) || (char_code_i inside {[CharTab:CharCr]});
  assign pc       = piece_lookup(char_code_i);

  // Per-character state update
  always_comb begin
    maps_d   = maps_q;
    sq_d     = sq_q;
    tok_d    = tok_q;
    in_tok_d = in_tok_q;
    len_d    = len_q;
    side_d   = side_q;
    rights_d = rights_q;
    pass_d   = pass_q;

    if (is_space) begin
      in_tok_d = 1'b0;
    end else begin
      if (!in_tok_q) begin
        in_tok_d = 1'b1;
        if (tok_q < TokMax) begin
          tok_d = tok_q + 3'd1;
          if (tok_d <= TokPass) len_d = 2'd0;
        end
      end

      case (tok_d)
        TokPlace: begin
          if (char_code_i == CharSlash) begin
            sq_d = sq_q - SqRank;
          end else if (char_code_i inside {[CharZero:CharNine]}) begin
            sq_d = sq_q + {4'b0, char_code_i[3:0]};
          end else begin
            if (sq_q < 8'(BoardSq) && pc.hit) begin
              maps_d[pc.idx][sq_q[5:0]] = 1'b1;
            end
            sq_d = sq_q + 8'd1;
          end
        end
        TokSide: begin
          side_d = (len_d == 2'd0) ? char_code_i : 8'd0;
        end
        TokCastle: begin
          if (char_code_i == CharUpK)  rights_d[0] = 1'b1;
          if (char_code_i == CharUpQ)  rights_d[1] = 1'b1;
          if (char_code_i == CharLowK) rights_d[2] = 1'b1;
          if (char_code_i == CharLowQ) rights_d[3] = 1'b1;
        end
        TokPass: begin
          if (len_d == 2'd0) begin
            pass_d[7:0] = char_code_i;
          end else if (len_d == 2'd1) begin
            pass_d[15:8] = char_code_i;
          end
        end
        default: ;
      endcase

      if (tok_d >= TokPlace && tok_d <= TokPass && len_d != 2'd3) begin
        len_d = len_d + 2'd1;
      end
    end
  end

  // Run record, taken from the updated state on the final character
  assign rank_w = {4'b0, pass_d[15:8]} - EpW'(CharOne);
  assign file_w = {4'b0, pass_d[7:0]}  - EpW'(CharLowA);

  always_comb begin
    rec_o.maps   = maps_d;
    rec_o.white  = (side_d == CharLowW);
    rec_o.rights = rights_d;
    if (tok_d >= TokPass && len_d == 2'd1 && pass_d[7:0] == CharDash) begin
      rec_o.ep = '1;
    end else begin
      rec_o.ep = (rank_w << 3) + file_w;
    end
  end

  assign push_o = accept_i && end_of_text_i;

  // Parser state; cleared again after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maps_q   <= '0;
      sq_q     <= SqStart;
      tok_q    <= '0;
      in_tok_q <= 1'b0;
      len_q    <= '0;
      side_q   <= '0;
      rights_q <= '0;
      pass_q   <= '0;
    end else if (accept_i) begin
      if (end_of_text_i) begin
        maps_q   <= '0;
        sq_q     <= SqStart;
        tok_q    <= '0;
        in_tok_q <= 1'b0;
        len_q    <= '0;
        side_q   <= '0;
        rights_q <= '0;
        pass_q   <= '0;
      end else begin
        maps_q   <= maps_d;
        sq_q     <= sq_d;
        tok_q    <= tok_d;
        in_tok_q <= in_tok_d;
        len_q    <= len_d;
        side_q   <= side_d;
        rights_q <= rights_d;
        pass_q   <= pass_d;
      end
    end
  end

endmodule

/* hw/rtl/fpp_queue.sv */
// Two-entry queue of finished run records between front and back end.
module fpp_queue import fpp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  run_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output run_rec_t head_o
);

  run_rec_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i))
    else $error("run queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("run queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("run queue count out of range");
`endif

endmodule

/* hw/rtl/fpp_back.sv */
// Back end: walks the head record and emits its twelve occupancy maps.
module fpp_back import fpp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rec_valid_i,
  input  run_rec_t              rec_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MapIdxW-1:0]    map_index_o,
  output logic [BoardSq-1:0]    occupancy_o,
  output logic                  white_to_move_o,
  output logic [3:0]            castling_rights_o,
  output logic [EpW-1:0]        en_passant_o,
  output logic                  last_result_o
);

  logic [MapIdxW-1:0] idx_q, idx_d;
  logic               valid_q, valid_d;
  logic               load;

  // Output register takes a new transaction when empty or being drained
  assign load  = rec_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load && (idx_q == LastMap);

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = (idx_q == LastMap) ? '0 : idx_q + 1'b1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Map counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      map_index_o       <= idx_q;
      occupancy_o       <= rec_i.maps[idx_q];
      white_to_move_o   <= rec_i.white;
      castling_rights_o <= rec_i.rights;
      en_passant_o      <= rec_i.ep;
      last_result_o     <= (idx_q == LastMap);
    end
  end

  assign out_valid_o = valid_q;

`ifndef SYNTHESIS
  a_last_is_final_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |-> map_index_o == LastMap)
    else $error("last result flag on wrong map");
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> rec_valid_i)
    else $error("record left the queue mid-emission");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastMap)
    else $error("map counter out of range");
`endif

endmodule

/* hw/rtl/fen_position_parser_top.sv */
// Throughput: one character per cycle; each run emits twelve results on successive cycles
// while out_ready_i is high. A run's final character writes its record into the queue,
// and the output register then loads its first map. The two-entry record queue lets the
// parser run ahead while maps are still emitted; input stalls only when both entries are held.
// Reset (rst_ni, asynchronous, active low) clears the parser state, the queue pointers
// and the output valid at once; no clearing pass follows.
module fen_position_parser_top import fpp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             char_code_i,
  input  logic                   end_of_text_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [MapIdxW-1:0]     map_index_o,
  output logic [BoardSq-1:0]     occupancy_o,
  output logic                   white_to_move_o,
  output logic [3:0]             castling_rights_o,
  output logic signed [EpW-1:0]  en_passant_o,
  output logic                   last_result_o
);

  logic           accept;
  logic           push, pop, q_full, q_valid;
  run_rec_t       rec_in, rec_head;
  logic [EpW-1:0] ep;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  fpp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .rec_o         (rec_in)
  );

  fpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (rec_head)
  );

  fpp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_valid_i       (q_valid),
    .rec_i             (rec_head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .map_index_o       (map_index_o),
    .occupancy_o       (occupancy_o),
    .white_to_move_o   (white_to_move_o),
    .castling_rights_o (castling_rights_o),
    .en_passant_o      (ep),
    .last_result_o     (last_result_o)
  );

  assign en_passant_o = $signed(ep);

endmodule

/* test/fen_position_parser_top_tb.sv */
// Self-checking testbench for the position text parser: directed texts, then random ones.
module fen_position_parser_top_tb;
  import fpp_pkg::*;

  // Piece letters in map order, first letter in the top byte
  localparam logic [NumMaps*8-1:0] PieceLetters = "PNBRQKpnbrqk";
  localparam int unsigned          DrainCycles  = 8;

  typedef struct packed {
    logic [MapIdxW-1:0] idx;
    logic [BoardSq-1:0] occ;
    logic               white;
    logic [3:0]         rights;
    logic [EpW-1:0]     ep;
    logic               last;
  } map_rec_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            char_code_i;
  logic                  end_of_text_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [MapIdxW-1:0]    map_index_o;
  logic [BoardSq-1:0]    occupancy_o;
  logic                  white_to_move_o;
  logic [3:0]            castling_rights_o;
  logic signed [EpW-1:0] en_passant_o;
  logic                  last_result_o;

  // Parser state as predicted from the accepted characters
  logic [BoardSq-1:0] board_maps [NumMaps];
  logic [7:0]         square_ptr;
  logic [2:0]         token_cnt;
  logic               in_token;
  logic [1:0]         token_len;
  logic [7:0]         side_char;
  logic [3:0]         castle_bits;
  logic [15:0]        ep_chars;

  map_rec_t   map_q [$];
  logic [7:0] text_q [$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         chars_sent;
  int         err_count;

  fen_position_parser_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .char_code_i       (char_code_i),
    .end_of_text_i     (end_of_text_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .map_index_o       (map_index_o),
    .occupancy_o       (occupancy_o),
    .white_to_move_o   (white_to_move_o),
    .castling_rights_o (castling_rights_o),
    .en_passant_o      (en_passant_o),
    .last_result_o     (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[fen_position_parser_top] ERROR");
    $finish;
  end

  function automatic logic is_blank(logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  task automatic reset_parser();
    for (int i = 0; i < NumMaps; i++) board_maps[i] = '0;
    square_ptr  = SqStart;
    token_cnt   = '0;
    in_token    = 1'b0;
    token_len   = '0;
    side_char   = '0;
    castle_bits = '0;
    ep_chars    = '0;
  endtask

  // Advance the predicted state by one character; on the final one queue the twelve maps
  task automatic parse_char(input logic [7:0] c, input logic eot);
    logic [EpW-1:0] ep_val;
    int             file_off;
    int             rank_off;
    map_rec_t       rec;
    if (is_blank(c)) begin
      in_token = 1'b0;
    end else begin
      if (!in_token) begin
        in_token = 1'b1;
        if (token_cnt < TokMax) begin
          token_cnt = token_cnt + 3'd1;
          if (token_cnt <= TokPass) token_len = '0;
        end
      end
      case (token_cnt)
        TokPlace: begin
          if (c == CharSlash) begin
            square_ptr = square_ptr - SqRank;
          end else if (c >= CharZero && c <= CharNine) begin
            square_ptr = square_ptr + (c - CharZero);
          end else begin
            if (square_ptr < BoardSq) begin
              for (int i = 0; i < NumMaps; i++) begin
                if (PieceLetters[8*(NumMaps-1-i) +: 8] == c) board_maps[i][square_ptr[5:0]] = 1'b1;
              end
            end
            square_ptr = square_ptr + 8'd1;
          end
        end
        TokSide: begin
          side_char = (token_len == 2'd0) ? c : 8'd0;
        end
        TokCastle: begin
          if (c == CharUpK)  castle_bits[0] = 1'b1;
          if (c == CharUpQ)  castle_bits[1] = 1'b1;
          if (c == CharLowK) castle_bits[2] = 1'b1;
          if (c == CharLowQ) castle_bits[3] = 1'b1;
        end
        TokPass: begin
          if (token_len == 2'd0)      ep_chars[7:0]  = c;
          else if (token_len == 2'd1) ep_chars[15:8] = c;
        end
        default: ;
      endcase
      // Length only counts within the four used tokens
      if (token_cnt >= TokPlace && token_cnt <= TokPass && token_len != 2'd3) begin
        token_len = token_len + 2'd1;
      end
    end

    if (eot) begin
      if (token_cnt >= TokPass && token_len == 2'd1 && ep_chars[7:0] == CharDash) begin
        ep_val = '1;
      end else begin
        file_off = ep_chars[7:0];
        rank_off = ep_chars[15:8];
        file_off = file_off - CharLowA;
        rank_off = rank_off - CharOne;
        ep_val   = EpW'(rank_off * 8 + file_off);
      end
      for (int i = 0; i < NumMaps; i++) begin
        rec.idx    = MapIdxW'(i);
        rec.occ    = board_maps[i];
        rec.white  = (side_char == CharLowW);
        rec.rights = castle_bits;
        rec.ep     = ep_val;
        rec.last   = (rec.idx == LastMap);
        map_q.push_back(rec);
      end
      reset_parser();
    end
  endtask

  // Offer one character, with random idle cycles in front, and wait for the transaction
  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    char_code_i   = c;
    end_of_text_i = eot;
    do @(posedge clk_i); while (!in_ready_o);
    parse_char(c, eot);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    for (int k = 0; k < text_q.size(); k++) send_char(text_q[k], k == text_q.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    send_text();
  endtask

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 2) != 0) return CharSpace;
    return 8'($urandom_range(CharTab, CharCr));
  endfunction

  function automatic logic [7:0] piece_char();
    return PieceLetters[8*$urandom_range(0, NumMaps-1) +: 8];
  endfunction

  // Mostly well-formed position texts with random content; some noise and cut-off texts
  task automatic build_random_text();
    int n_tok;
    int n_rank;
    int pick;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 7) == 0) text_q.push_back(blank_char());
    n_tok = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(4, 6);
    for (int t = 1; t <= n_tok; t++) begin
      if (t > 1) repeat ($urandom_range(1, 2)) text_q.push_back(blank_char());
      case (t)
        TokPlace: begin
          n_rank = $urandom_range(1, 8);
          for (int r = 0; r < n_rank; r++) begin
            if (r > 0) text_q.push_back(CharSlash);
            repeat ($urandom_range(1, 4)) begin
              pick = $urandom_range(0, 99);
              if (pick < 60)      text_q.push_back(piece_char());
              else if (pick < 85) text_q.push_back(8'($urandom_range(CharZero, CharNine)));
              else                text_q.push_back(8'($urandom_range(0, 255)));
            end
          end
        end
        TokSide: begin
          pick = $urandom_range(0, 9);
          if (pick < 5)      text_q.push_back(CharLowW);
          else if (pick < 8) text_q.push_back(8'h62);
          else if (pick < 9) repeat (2) text_q.push_back(CharLowW);
          else               text_q.push_back(8'($urandom_range(33, 126)));
        end
        TokCastle: begin
          if ($urandom_range(0, 1)) text_q.push_back(CharUpK);
          if ($urandom_range(0, 1)) text_q.push_back(CharUpQ);
          if ($urandom_range(0, 1)) text_q.push_back(CharLowK);
          if ($urandom_range(0, 1)) text_q.push_back(CharLowQ);
          if ($urandom_range(0, 5) == 0) text_q.push_back(8'($urandom_range(33, 126)));
          if (text_q[$] == CharSpace || is_blank(text_q[$])) text_q.push_back(CharDash);
        end
        TokPass: begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            text_q.push_back(CharDash);
          end else if (pick < 8) begin
            text_q.push_back(8'($urandom_range(CharLowA, CharLowA + 7)));
            text_q.push_back(8'($urandom_range(CharOne, CharOne + 7)));
          end else begin
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(33, 255)));
          end
        end
        default: begin
          repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(CharZero, CharNine)));
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0) text_q.push_back(blank_char());
  endtask

  // A lone top-code character: placement only, all later tokens missing
  task automatic test_single_char_text();
    text_q = '{8'hFF};
    send_text();
  endtask

  // Slash, digit, piece and non-letter in placement; full side, castling and dash
  task automatic test_all_token_kinds();
    send_string("rR/9.q w KQkq -");
  endtask

  // Counter wraps below a1; long side token; no en passant token
  task automatic test_off_board_square();
    send_string("////N\tww\nq");
  endtask

  task automatic test_random_texts(input int idle_in, input int stall_out, input int n_chars);
    int stop_at;
    send_idle_pct  = idle_in;
    recv_stall_pct = stall_out;
    stop_at        = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      build_random_text();
      send_text();
    end
  endtask

  // Receiver stalls at random
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_field(input string fld, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
      err_count++;
    end
  endtask

  // Compare each output transaction with the oldest queued map
  always @(posedge clk_i) begin
    map_rec_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (map_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got map %0d", $time, map_index_o);
        err_count++;
      end else begin
        exp_r = map_q.pop_front();
        report_field("map_index", exp_r.idx, map_index_o);
        report_field("occupancy", exp_r.occ, occupancy_o);
        report_field("white_to_move", exp_r.white, white_to_move_o);
        report_field("castling_rights", exp_r.rights, castling_rights_o);
        // Compare the raw 12-bit field, without sign extension
        report_field("en_passant", exp_r.ep, $unsigned(en_passant_o));
        report_field("last_result", exp_r.last, last_result_o);
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    char_code_i    = '0;
    end_of_text_i  = 1'b0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    chars_sent     = 0;
    err_count      = 0;
    reset_parser();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_char_text();
    test_all_token_kinds();
    test_off_board_square();
    test_random_texts(0, 0, 115);
    test_random_texts(75, 0, 115);
    test_random_texts(0, 75, 115);
    test_random_texts(27, 27, 115);
    in_valid_i = 1'b0;

    // Drain the outstanding maps, then allow for the output latency
    while (map_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (err_count == 0) begin
      $display("[fen_position_parser_top] OK");
    end else begin
      $display("[fen_position_parser_top] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/fpp_pkg.sv
hw/rtl/fpp_front.sv
hw/rtl/fpp_queue.sv
hw/rtl/fpp_back.sv
hw/rtl/fen_position_parser_top.sv
test/fen_position_parser_top_tb.sv
